// ===== rtl/byte_keystream_xor_decryptor_unit_macros.svh =====
// Assertion helpers used by bkx_core.
`ifndef BYTE_KEYSTREAM_XOR_DECRYPTOR_UNIT_MACROS_SVH
`define BYTE_KEYSTREAM_XOR_DECRYPTOR_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BKX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define BKX_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bkx_pkg.sv =====
package bkx_pkg;

   localparam logic [2:0] HeaderLen      = 3'd4;
   localparam logic [1:0] KeySelectReset = 2'd1;

   // key_select codes
   localparam logic [1:0] KeySelPairA    = 2'd0;
   localparam logic [1:0] KeySelPairB    = 2'd1;
   localparam logic [1:0] KeySelPairC    = 2'd2;
   localparam logic [1:0] KeySelPass     = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } item_type;

   function automatic logic [31:0] add_const(input logic [1:0] sel);
      logic [31:0] c;
      case (sel)
         KeySelPairA: c = 32'h0000_0D22;
         KeySelPairB: c = 32'h0000_0F43;
         KeySelPairC: c = 32'h0000_0292;
         default:     c = 32'h0000_0000;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] mul_const(input logic [1:0] sel);
      logic [15:0] c;
      case (sel)
         KeySelPairA: c = 16'h0849;
         KeySelPairB: c = 16'h356B;
         KeySelPairC: c = 16'h57A7;
         default:     c = 16'h0000;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/byte_keystream_xor_decryptor_unit.sv =====
// Byte keystream XOR decryptor. Takes one encrypted byte per cycle on req_ and
// returns one decrypted byte per cycle on rsp_ while rsp_ready is high, through
// the input and result registers. The first four bytes of each file (first_byte,
// or the byte after last_byte) load the 32-bit key little-endian and produce no
// rsp_ transaction. Each later byte steps the key with one 32x16 multiply-add
// and a combinational feedback shift; that key recurrence sets the rate at one
// byte per cycle. key_select picks the constant pair (3 passes bytes through
// unchanged) and must be written only while no transaction is in flight.
module byte_keystream_xor_decryptor_unit
   import bkx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_plain_byte,
   output logic       rsp_last_out,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   item_type req_item;
   item_type item;
   logic     item_valid;
   logic     item_take;

   assign req_item.data_byte  = req_data_byte;
   assign req_item.first_byte = req_first_byte;
   assign req_item.last_byte  = req_last_byte;

   bkx_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   bkx_core u_core (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_plain_byte   (rsp_plain_byte),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

// ===== rtl/bkx_in_stage.sv =====
module bkx_in_stage
   import bkx_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   output logic     item_valid,
   output item_type item,
   input  logic     item_take
);

   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff;
   logic     req_take;

   assign req_ready = !in_valid_ff || item_take;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (item_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   assign item_valid = in_valid_ff;
   assign item       = in_item_ff;

endmodule

// ===== rtl/bkx_core.sv =====
`include "byte_keystream_xor_decryptor_unit_macros.svh"

module bkx_core
   import bkx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_take,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_plain_byte,
   output logic       rsp_last_out
);

   logic [1:0]  key_select_ff;
   logic [2:0]  hc_ff, hc_in;
   logic [31:0] key_ff, key_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  plain_ff;
   logic        last_ff;

   logic [2:0]  hc_eff;
   logic        emit;
   logic [31:0] prod;
   logic [31:0] v;
   logic [31:0] key_next;
   logic        feedback;

   // first_byte restarts header collection before the byte is used
   assign hc_eff = item.first_byte ? 3'd0 : hc_ff;
   assign emit   = item_valid && (hc_eff == HeaderLen);

   // header bytes never wait on the result side
   assign item_take = item_valid && (!emit || !rsp_valid_ff || rsp_ready);

   // keep only the low 32 bits of the product, the key wraps mod 2^32
   assign prod     = key_ff * {16'd0, mul_const(key_select_ff)};
   assign v        = add_const(key_select_ff) + prod;
   assign feedback = v[22] ^ v[10] ^ v[0];
   assign key_next = {feedback, v[31:1]};

   always_comb begin
      key_in = key_ff;
      hc_in  = hc_ff;
      if (item_take) begin
         if (emit) begin
            key_in = key_next;
            hc_in  = hc_eff;
         end else begin
            if (hc_eff == 3'd0) begin
               key_in = {24'd0, item.data_byte};
            end else begin
               key_in = key_ff | ({24'd0, item.data_byte} << {hc_eff[1:0], 3'b000});
            end
            hc_in = hc_eff + 3'd1;
         end
         if (item.last_byte) begin
            hc_in = 3'd0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_select_ff <= KeySelectReset;
         hc_ff         <= 3'd0;
         key_ff        <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            key_select_ff <= csr_write_data;
         end
         hc_ff        <= hc_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         plain_ff <= item.data_byte ^ key_next[7:0];
         last_ff  <= item.last_byte;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = plain_ff;
   assign rsp_last_out   = last_ff;

   `BKX_ASSERT(hc_in_range, clock, reset, hc_ff <= HeaderLen, "header count beyond header length")
   `BKX_ASSERT(emit_sets_valid, clock, reset, (item_take && emit) |=> rsp_valid_ff, "result lost")
   `BKX_ASSERT(last_restarts_header, clock, reset, (item_take && item.last_byte) |=> (hc_ff == 3'd0), "header not restarted after last byte")
   `BKX_ASSERT(pass_mode_zero_key, clock, reset, (item_take && emit && key_select_ff == KeySelPass) |=> (key_ff == 32'd0), "pass-through mode left a nonzero key")
   `BKX_ASSERT(no_overwrite, clock, reset, (rsp_valid_ff && !rsp_ready) |-> !(item_take && emit), "pending result overwritten")

endmodule

// ===== dv/byte_keystream_xor_decryptor_unit_tb.sv =====
`timescale 1ns / 1ps

module byte_keystream_xor_decryptor_unit_tb;
   import bkx_pkg::*;

   localparam int CycleLimit   = 250000;
   localparam int PhaseBytes   = 180;
   localparam int SettleCycles = 6;
   localparam int HoldCycles   = 300;

   typedef struct packed {
      logic [7:0] plain;
      logic       last;
   } plain_rec_type;

   typedef struct packed {
      logic [1:0] sel;
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       given;
      logic       quiet;
      logic [7:0] want_byte;
      logic       want_last;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_first_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_plain_byte;
   logic       rsp_last_out;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;

   // expectation typed into the directed rows, carried along with the payload
   logic       req_given;
   logic       req_quiet;
   logic [7:0] req_want_byte;
   logic       req_want_last;

   plain_rec_type pending_plain[$];
   logic [1:0] active_sel;
   logic [2:0] hdr_count;
   logic [31:0] key_reg;
   int         error_count;
   int         cycle_count;
   int         tx_burst;
   int         rx_burst;
   int         file_left;
   bit         rx_hold;
   dir_row_type directed_rows[28];
   logic [1:0] phase_sel[8];

   byte_keystream_xor_decryptor_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_plain_byte   (rsp_plain_byte),
      .rsp_last_out     (rsp_last_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [31:0] next_key(input logic [31:0] k, input logic [1:0] sel);
      logic [31:0] a;
      logic [31:0] m;
      logic [31:0] v;
      case (sel)
         KeySelPairA: begin a = 32'hD22; m = 32'h849;  end
         KeySelPairB: begin a = 32'hF43; m = 32'h356B; end
         KeySelPairC: begin a = 32'h292; m = 32'h57A7; end
         default:     begin a = 32'h0;   m = 32'h0;    end
      endcase
      v = a + k * m;
      return {v[22] ^ v[10] ^ v[0], v[31:1]};
   endfunction

   // Advance the decryptor state by one byte; emits is low while a header loads.
   task automatic decrypt_byte(input logic [7:0] b, input logic f, input logic l,
                               output bit emits, output plain_rec_type rec);
      emits = 1'b0;
      rec   = '0;
      if (f)
         hdr_count = '0;
      if (hdr_count < HeaderLen) begin
         if (hdr_count == 0)
            key_reg = {24'h0, b};
         else
            key_reg = key_reg | (32'(b) << (8 * hdr_count));
         hdr_count = hdr_count + 3'd1;
      end else begin
         key_reg   = next_key(key_reg, active_sel);
         rec.plain = b ^ key_reg[7:0];
         rec.last  = l;
         emits     = 1'b1;
      end
      if (l)
         hdr_count = '0;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
   endtask

   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0)
         burst = $urandom_range(20, 60);
      return $urandom_range(0, 13);
   endfunction

   always @(posedge clock) begin : check_proc
      bit            emits;
      plain_rec_type rec;
      plain_rec_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_plain.size() == 0) begin
               report_mismatch("unexpected result, plain_byte", rsp_plain_byte, 0);
            end else begin
               want = pending_plain.pop_front();
               if (rsp_plain_byte !== want.plain)
                  report_mismatch("plain_byte", rsp_plain_byte, want.plain);
               if (rsp_last_out !== want.last)
                  report_mismatch("last_out", rsp_last_out, want.last);
            end
         end
         if (req_valid && req_ready) begin
            decrypt_byte(req_data_byte, req_first_byte, req_last_byte, emits, rec);
            if (req_given) begin
               emits     = !req_quiet;
               rec.plain = req_want_byte;
               rec.last  = req_want_last;
            end
            if (emits)
               pending_plain.push_back(rec);
         end
      end
   end

   // Receiver: random backpressure, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin : rx_loop
         int w;
         if (rx_hold) begin
            rx_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         w = draw_wait(rx_burst);
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
                            input logic given, input logic quiet,
                            input logic [7:0] wb, input logic wl, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_first_byte <= f;
      req_last_byte  <= l;
      req_given      <= given;
      req_quiet      <= quiet;
      req_want_byte  <= wb;
      req_want_last  <= wl;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_plain.size() != 0) @(posedge clock);
   endtask

   // Let pending results and header bytes still in flight clear out before touching key_select.
   task automatic select_key(input logic [1:0] sel);
      drain_results();
      repeat (SettleCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= sel;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_sel = sel;
   endtask

   // Mostly well-formed files with random content; some short, some restarted.
   task automatic random_byte(output logic [7:0] b, output logic f, output logic l);
      if (file_left == 0) begin
         file_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 24);
         f = ($urandom_range(0, 9) != 0);
      end else begin
         f = ($urandom_range(0, 39) == 0);
      end
      l = (file_left == 1) || ($urandom_range(0, 49) == 0);
      b = 8'($urandom_range(0, 255));
      file_left--;
      if (l)
         file_left = 0;
   endtask

   initial begin : stim
      logic [7:0] b;
      logic       f;
      logic       l;
      int         gap;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_first_byte   = 1'b0;
      req_last_byte    = 1'b0;
      req_given        = 1'b0;
      req_quiet        = 1'b0;
      req_want_byte    = '0;
      req_want_last    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      active_sel       = KeySelectReset;
      hdr_count        = '0;
      key_reg          = '0;
      error_count      = 0;
      cycle_count      = 0;
      tx_burst         = 0;
      rx_burst         = 0;
      file_left        = 0;
      rx_hold          = 1'b0;

      //                sel          data   f     l     given quiet want   wl
      directed_rows = '{
         '{KeySelPairB, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0}, // new file, header
         '{KeySelPairB, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         '{KeySelPairB, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         '{KeySelPairB, 8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}, // end of file
         '{KeySelPairB, 8'h12, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0}, // header, no first
         '{KeySelPairB, 8'h34, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'h56, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'h78, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'h9A, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
         '{KeySelPairB, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0}, // restart mid-file
         '{KeySelPairB, 8'h01, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'h02, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0}, // short file
         '{KeySelPairB, 8'h80, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0}, // one-byte file
         '{KeySelPairB, 8'hAA, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'hBB, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'hCC, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'hDD, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPairB, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
         '{KeySelPass,  8'h11, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0}, // pass-through
         '{KeySelPass,  8'h22, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPass,  8'h33, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPass,  8'h44, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
         '{KeySelPass,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
         '{KeySelPass,  8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b0},
         '{KeySelPass,  8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, 8'h5A, 1'b1}
      };
      phase_sel = '{KeySelPairA, KeySelPairC, KeySelPairB, KeySelPass,
                    KeySelPairC, KeySelPairA, KeySelPass, KeySelPairB};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].sel != active_sel)
            select_key(directed_rows[i].sel);
         send_byte(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                   directed_rows[i].given, directed_rows[i].quiet,
                   directed_rows[i].want_byte, directed_rows[i].want_last,
                   draw_wait(tx_burst));
      end

      foreach (phase_sel[p]) begin
         select_key(phase_sel[p]);
         if (p == 2)
            rx_hold = 1'b1;
         for (int n = 0; n < PhaseBytes; n++) begin
            // keep offering back to back while the receiver holds off
            gap = (p == 2 && n < 80) ? 0 : draw_wait(tx_burst);
            if (p == 5 && n == PhaseBytes / 2)
               drain_results();
            random_byte(b, f, l);
            send_byte(b, f, l, 1'b0, 1'b0, 8'h00, 1'b0, gap);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== byte_keystream_xor_decryptor_unit.f =====
+incdir+rtl
rtl/bkx_pkg.sv
rtl/bkx_in_stage.sv
rtl/bkx_core.sv
rtl/byte_keystream_xor_decryptor_unit.sv
dv/byte_keystream_xor_decryptor_unit_tb.sv
